/* hw/rtl/aps_pkg.sv */
// Package for the box physics step engine: command and state codes, the entity
// record layout, fixed-point constants and the rounding and saturation helpers.
// Depends on nothing; used by the engine core.
package aps_pkg;

  localparam int FRAC_BITS = 8;

  localparam logic signed [31:0] ONE_Q      = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] NEW_SIZE   = 32'sd64 <<< FRAC_BITS;
  localparam logic signed [31:0] SPAWN_POS  = 32'sd200 <<< FRAC_BITS;
  localparam logic signed [31:0] DEAD_POS   = -(32'sd100000 <<< FRAC_BITS);
  localparam logic signed [31:0] SETTLE_LIM = 32'sd2 <<< FRAC_BITS;

  localparam logic signed [31:0] STEP_DT    = 32'sd1092;
  localparam logic signed [17:0] STEP_DT_M  = 18'sd1092;
  localparam logic signed [17:0] FRICTION_M = 18'sd58982;
  localparam logic [16:0]        STEP_DT_A  = 17'd1092;
  localparam logic [16:0]        DT_CLAMP   = 17'd16384;
  localparam logic [17:0]        ACC_MAX    = 18'd131071;
  localparam logic [8:0]         RESTI_MAX  = 9'd256;

  localparam int F_DYN   = 0;
  localparam int F_SEN   = 1;
  localparam int F_ALIVE = 2;

  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_FLOOR   = 2'd1;
  localparam logic [1:0] REG_RESTI   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    CMD_INIT    = 4'd0,
    CMD_CLEAR   = 4'd1,
    CMD_CREATE  = 4'd2,
    CMD_VEL     = 4'd3,
    CMD_BODY    = 4'd4,
    CMD_SIZE    = 4'd5,
    CMD_FILTER  = 4'd6,
    CMD_IMPULSE = 4'd7,
    CMD_DESTROY = 4'd8,
    CMD_STEP    = 4'd9,
    CMD_READ    = 4'd10
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_C_RD,
    S_C_LD,
    S_C_EX,
    S_C_WR,
    S_GRAV,
    S_GRAV_DONE,
    S_SUB_CHK,
    S_I_RD,
    S_I_LD,
    S_I_VY,
    S_I_XA,
    S_I_YA,
    S_I_FL,
    S_BNC_M,
    S_BNC_A,
    S_FRC_M,
    S_FRC_A,
    S_SETTLE,
    S_E_WR,
    S_P_RDA,
    S_P_RDB,
    S_P_LDB,
    S_P_CHK,
    S_P_SPAN,
    S_P_RES,
    S_SUB_END,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic [2:0]         flags;
    logic [31:0]        layer;
    logic [31:0]        mask;
  } rec_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic logic signed [50:0] rnd_shr(input logic signed [49:0] v,
                                                 input int unsigned s);
    logic signed [50:0] ve;
    logic [50:0]        mag;
    logic [50:0]        half;
    ve   = 51'(v);
    half = 51'd1 << (s - 1);
    mag  = v[49] ? 51'(-ve) : 51'(ve);
    mag  = (mag + half) >> s;
    return v[49] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [33:0] span(input logic signed [31:0] p0,
                                              input logic signed [31:0] l0,
                                              input logic signed [31:0] p1,
                                              input logic signed [31:0] l1);
    logic signed [33:0] e0;
    logic signed [33:0] e1;
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    e0 = 34'(p0) + 34'(l0);
    e1 = 34'(p1) + 34'(l1);
    hi = (e0 < e1) ? e0 : e1;
    lo = (p0 > p1) ? 34'(p0) : 34'(p1);
    return hi - lo;
  endfunction

  function automatic rec_t new_rec(input logic signed [31:0] x,
                                   input logic signed [31:0] y);
    rec_t r;
    r.x     = x;
    r.y     = y;
    r.vx    = '0;
    r.vy    = '0;
    r.w     = NEW_SIZE;
    r.h     = NEW_SIZE;
    r.flags = 3'b101;
    r.layer = 32'd1;
    r.mask  = 32'hffffffff;
    return r;
  endfunction

endpackage

/* hw/rtl/aps_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the entity table of the engine core.
module aps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/aabb_physics_step_engine_core.sv */
// Top level of the box physics step engine: command decoder, entity table and
// the sequencer that runs fixed substeps through one shared multiplier.
// Depends on aps_pkg and aps_ram.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+---------------------------------
//  command  | in        | in_valid_i / in_stall_o  | cmd, entity_id, values, flags
//  result   | out       | out_valid_o / out_stall_i| result_id, out_x/y/w/h, status
//  config   | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Clear, create into a full table and rejected requests finish on the accepting
// edge; init and create write the table directly, other entity commands read,
// modify and write back their record. A step runs its substeps in turn: each
// integrates every live dynamic box and then checks every entity pair, paced by
// the single table read port and the shared multiplier.
// Reset clears the table count and accumulator and sets the registers to their
// defaults; a request is taken only once the previous result is leaving.
module aabb_physics_step_engine_core #(
  parameter int MAX_ENTITIES = 64,
  parameter int MAX_SUBSTEPS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         cmd_i,
  input  logic [5:0]         entity_id_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic               dynamic_flag_i,
  input  logic               sensor_flag_i,
  input  logic [31:0]        layer_bits_i,
  input  logic [31:0]        mask_bits_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         result_id_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [30:0]        out_w_o,
  output logic [30:0]        out_h_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import aps_pkg::*;

  localparam int IW = $clog2(MAX_ENTITIES);
  localparam int CW = $clog2(MAX_ENTITIES + 1);
  localparam int SW = $clog2(MAX_SUBSTEPS + 1);

  state_e state_q, state_d;

  logic [CW-1:0]      count_q;
  logic [16:0]        acc_q;
  logic [SW-1:0]      steps_q;
  logic [CW-1:0]      i_q, j_q;
  logic               pair_q;
  logic               out_valid_q;
  logic [23:0]        grav_q;
  logic signed [31:0] floor_q;
  logic [8:0]         resti_q;

  rec_t               w_q, s_q, a_q, b_q, rd_rec;
  logic [IW-1:0]      w_addr_q, id_q;
  cmd_e               cmd_q, cmd_in;
  logic signed [31:0] op_x_q, op_y_q;
  logic               dyn_q, sen_q;
  logic [31:0]        layer_q, mask_q;
  logic signed [49:0] prod_q;
  logic signed [19:0] dv_q;
  logic signed [33:0] px_q, py_q;
  logic [5:0]         res_id_q;
  logic signed [31:0] res_x_q, res_y_q;
  logic [30:0]        res_w_q, res_h_q;
  logic [1:0]         res_st_q;

  logic               accept, finish, imm_done;
  logic [CW+5:0]      id_ext, cnt_ext;
  logic               id_ok, table_full, per_entity;
  logic [16:0]        dt_cl;
  logic [17:0]        acc_sum;
  logic [16:0]        acc_new;
  logic               sub_go, integ_more, pair_more_j, pair_more_i, has_pairs;
  logic               rd_active, floor_hit, vy_pos, pair_hit, a_is_dyn;
  logic               touch, layer_ok;
  logic [IW-1:0]      raddr;
  logic               we;
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] prod;
  logic [$bits(rec_t)-1:0] rdata;

  aps_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(MAX_ENTITIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(w_addr_q),
    .wdata_i(w_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_rec = rec_t'(rdata);
  assign cmd_in = cmd_e'(cmd_i);

  assign in_stall_o  = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign id_ext     = (CW + 6)'(entity_id_i);
  assign cnt_ext    = (CW + 6)'(count_q);
  assign id_ok      = id_ext < cnt_ext;
  assign table_full = count_q == CW'(MAX_ENTITIES);
  assign per_entity = (cmd_in == CMD_VEL) || (cmd_in == CMD_BODY) || (cmd_in == CMD_SIZE) ||
                      (cmd_in == CMD_FILTER) || (cmd_in == CMD_IMPULSE) ||
                      (cmd_in == CMD_DESTROY) || (cmd_in == CMD_READ);
  assign imm_done   = accept && ((cmd_in == CMD_CLEAR) ||
                                 ((cmd_in == CMD_CREATE) && table_full) ||
                                 (per_entity && !id_ok) ||
                                 (!per_entity && (cmd_in != CMD_INIT) &&
                                  (cmd_in != CMD_CREATE) && (cmd_in != CMD_STEP)));
  assign finish     = imm_done || (state_q == S_C_WR) || (state_q == S_DONE);

  assign dt_cl   = (17'(time_step_i) > DT_CLAMP) ? DT_CLAMP : 17'(time_step_i);
  assign acc_sum = 18'(acc_q) + 18'(dt_cl);
  assign acc_new = (acc_sum > ACC_MAX) ? 17'(ACC_MAX) : acc_sum[16:0];

  assign sub_go      = (acc_q >= STEP_DT_A) && (steps_q < SW'(MAX_SUBSTEPS));
  assign integ_more  = ((CW + 1)'(i_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
  assign pair_more_j = ((CW + 1)'(j_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
  assign pair_more_i = ((CW + 1)'(i_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);
  assign has_pairs   = (CW + 1)'(count_q) >= (CW + 1)'(2);

  assign rd_active = rd_rec.flags[F_ALIVE] && rd_rec.flags[F_DYN];
  assign floor_hit = (33'(w_q.y) + 33'(w_q.h)) > 33'(floor_q);
  assign vy_pos    = w_q.vy > 32'sd0;

  assign touch    = a_q.flags[F_ALIVE] && b_q.flags[F_ALIVE] &&
                    (33'(a_q.x) < 33'(b_q.x) + 33'(b_q.w)) &&
                    (33'(a_q.x) + 33'(a_q.w) > 33'(b_q.x)) &&
                    (33'(a_q.y) < 33'(b_q.y) + 33'(b_q.h)) &&
                    (33'(a_q.y) + 33'(a_q.h) > 33'(b_q.y));
  assign layer_ok = ((a_q.layer & b_q.mask) != 32'd0) || ((b_q.layer & a_q.mask) != 32'd0);
  assign pair_hit = touch && !(a_q.flags[F_SEN] || b_q.flags[F_SEN]) && layer_ok &&
                    (a_q.flags[F_DYN] != b_q.flags[F_DYN]);
  assign a_is_dyn = a_q.flags[F_DYN];

  assign prod = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_INIT:   state_d = S_C_WR;
            CMD_CREATE: state_d = table_full ? S_IDLE : S_C_WR;
            CMD_STEP:   state_d = S_GRAV;
            default:    state_d = (per_entity && id_ok) ? S_C_RD : S_IDLE;
          endcase
        end
      end
      S_C_RD:      state_d = S_C_LD;
      S_C_LD:      state_d = S_C_EX;
      S_C_EX:      state_d = S_C_WR;
      S_C_WR:      state_d = S_IDLE;
      S_GRAV:      state_d = S_GRAV_DONE;
      S_GRAV_DONE: state_d = S_SUB_CHK;
      S_SUB_CHK: begin
        if (!sub_go) begin
          state_d = S_DONE;
        end else if (count_q != '0) begin
          state_d = S_I_RD;
        end else begin
          state_d = S_SUB_END;
        end
      end
      S_I_RD: state_d = S_I_LD;
      S_I_LD: begin
        if (rd_active) begin
          state_d = S_I_VY;
        end else if (integ_more) begin
          state_d = S_I_RD;
        end else begin
          state_d = has_pairs ? S_P_RDA : S_SUB_END;
        end
      end
      S_I_VY: state_d = S_I_XA;
      S_I_XA: state_d = S_I_YA;
      S_I_YA: state_d = S_I_FL;
      S_I_FL: begin
        if (floor_hit) begin
          state_d = vy_pos ? S_BNC_M : S_SETTLE;
        end else begin
          state_d = S_E_WR;
        end
      end
      S_BNC_M: state_d = S_BNC_A;
      S_BNC_A: state_d = pair_q ? S_FRC_M : S_SETTLE;
      S_FRC_M: state_d = S_FRC_A;
      S_FRC_A: state_d = S_SETTLE;
      S_SETTLE: state_d = S_E_WR;
      S_E_WR: begin
        if (!pair_q) begin
          if (integ_more) begin
            state_d = S_I_RD;
          end else begin
            state_d = has_pairs ? S_P_RDA : S_SUB_END;
          end
        end else begin
          state_d = (pair_more_j || pair_more_i) ? S_P_RDA : S_SUB_END;
        end
      end
      S_P_RDA: state_d = S_P_RDB;
      S_P_RDB: state_d = S_P_LDB;
      S_P_LDB: state_d = S_P_CHK;
      S_P_CHK: begin
        if (pair_hit) begin
          state_d = S_P_SPAN;
        end else begin
          state_d = (pair_more_j || pair_more_i) ? S_P_RDA : S_SUB_END;
        end
      end
      S_P_SPAN: state_d = S_P_RES;
      S_P_RES: begin
        if (py_q <= px_q) begin
          state_d = vy_pos ? S_BNC_M : S_FRC_M;
        end else begin
          state_d = S_E_WR;
        end
      end
      S_SUB_END: state_d = S_SUB_CHK;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    raddr = i_q[IW-1:0];
    we    = 1'b0;
    mul_a = w_q.vx;
    mul_b = STEP_DT_M;
    case (state_q)
      S_C_RD:  raddr = id_q;
      S_P_RDB: raddr = j_q[IW-1:0];
      S_C_WR:  we = 1'b1;
      S_E_WR:  we = 1'b1;
      S_GRAV:  mul_a = 32'(grav_q);
      S_I_XA:  mul_a = w_q.vy;
      S_BNC_M: begin
        mul_a = w_q.vy;
        mul_b = 18'(resti_q);
      end
      S_FRC_M: mul_b = FRICTION_M;
      default: raddr = i_q[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      acc_q       <= '0;
      steps_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pair_q      <= 1'b0;
      out_valid_q <= 1'b0;
      grav_q      <= 24'd250880;
      floor_q     <= 32'sd230400;
      resti_q     <= '0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GRAVITY: grav_q  <= cfg_data_i[23:0];
          REG_FLOOR:   floor_q <= cfg_data_i;
          REG_RESTI:   resti_q <= (cfg_data_i[8:0] > RESTI_MAX) ? RESTI_MAX : cfg_data_i[8:0];
          default:     grav_q  <= grav_q;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (cmd_in)
              CMD_INIT: begin
                count_q <= CW'(1);
                acc_q   <= '0;
              end
              CMD_CLEAR: begin
                count_q <= '0;
                acc_q   <= '0;
              end
              CMD_CREATE: begin
                if (!table_full) begin
                  count_q <= count_q + CW'(1);
                end
              end
              CMD_STEP: begin
                acc_q   <= acc_new;
                steps_q <= '0;
              end
              default: acc_q <= acc_q;
            endcase
          end
        end
        S_SUB_CHK: begin
          i_q    <= '0;
          j_q    <= CW'(1);
          pair_q <= 1'b0;
        end
        S_I_LD: begin
          if (!rd_active) begin
            if (integ_more) begin
              i_q <= i_q + CW'(1);
            end else begin
              i_q    <= '0;
              j_q    <= CW'(1);
              pair_q <= 1'b1;
            end
          end
        end
        S_E_WR, S_P_CHK: begin
          if (!pair_q) begin
            if (integ_more) begin
              i_q <= i_q + CW'(1);
            end else begin
              i_q    <= '0;
              j_q    <= CW'(1);
              pair_q <= 1'b1;
            end
          end else if (state_q == S_E_WR || !pair_hit) begin
            if (pair_more_j) begin
              j_q <= j_q + CW'(1);
            end else if (pair_more_i) begin
              i_q <= i_q + CW'(1);
              j_q <= i_q + CW'(2);
            end
          end
        end
        S_SUB_END: begin
          acc_q   <= acc_q - STEP_DT_A;
          steps_q <= steps_q + SW'(1);
        end
        default: pair_q <= pair_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q    <= cmd_in;
          id_q     <= id_ext[IW-1:0];
          op_x_q   <= value_x_i;
          op_y_q   <= value_y_i;
          dyn_q    <= dynamic_flag_i;
          sen_q    <= sensor_flag_i;
          layer_q  <= layer_bits_i;
          mask_q   <= mask_bits_i;
          res_x_q  <= '0;
          res_y_q  <= '0;
          res_w_q  <= '0;
          res_h_q  <= '0;
          case (cmd_in)
            CMD_INIT: begin
              w_q      <= new_rec(SPAWN_POS, SPAWN_POS);
              w_addr_q <= '0;
              res_id_q <= '0;
              res_st_q <= ST_OK;
            end
            CMD_CLEAR: begin
              res_id_q <= '0;
              res_st_q <= ST_OK;
            end
            CMD_CREATE: begin
              if (table_full) begin
                res_id_q <= '0;
                res_st_q <= ST_FULL;
              end else begin
                w_q      <= new_rec(value_x_i, value_y_i);
                w_addr_q <= count_q[IW-1:0];
                res_id_q <= cnt_ext[5:0];
                res_st_q <= ST_OK;
              end
            end
            CMD_STEP: begin
              res_id_q <= '0;
              res_st_q <= ST_OK;
            end
            default: begin
              if (per_entity && id_ok) begin
                res_id_q <= entity_id_i;
                w_addr_q <= id_ext[IW-1:0];
                res_st_q <= ST_OK;
              end else begin
                res_id_q <= '0;
                res_st_q <= ST_INVALID;
              end
            end
          endcase
        end
      end
      S_C_LD: w_q <= rd_rec;
      S_C_EX: begin
        case (cmd_q)
          CMD_VEL: begin
            w_q.vx <= op_x_q;
            w_q.vy <= op_y_q;
          end
          CMD_BODY: w_q.flags <= {w_q.flags[F_ALIVE], sen_q, dyn_q};
          CMD_SIZE: begin
            w_q.w <= (op_x_q < ONE_Q) ? ONE_Q : op_x_q;
            w_q.h <= (op_y_q < ONE_Q) ? ONE_Q : op_y_q;
          end
          CMD_FILTER: begin
            w_q.layer <= layer_q;
            w_q.mask  <= mask_q;
          end
          CMD_IMPULSE: begin
            if (w_q.flags[F_DYN]) begin
              w_q.vx <= sat32(51'(w_q.vx) + 51'(op_x_q));
              w_q.vy <= sat32(51'(w_q.vy) + 51'(op_y_q));
            end else begin
              res_st_q <= ST_INVALID;
            end
          end
          CMD_DESTROY: w_q.flags[F_ALIVE] <= 1'b0;
          CMD_READ: begin
            if (w_q.flags[F_ALIVE]) begin
              res_x_q <= w_q.x;
              res_y_q <= w_q.y;
              res_w_q <= w_q.w[30:0];
              res_h_q <= w_q.h[30:0];
            end else begin
              res_x_q <= DEAD_POS;
              res_y_q <= DEAD_POS;
            end
          end
          default: res_st_q <= res_st_q;
        endcase
      end
      S_GRAV_DONE: dv_q <= 20'(rnd_shr(prod_q, 16));
      S_I_LD: begin
        w_q      <= rd_rec;
        w_addr_q <= i_q[IW-1:0];
      end
      S_I_VY: w_q.vy <= sat32(51'(w_q.vy) + 51'(dv_q));
      S_I_XA: w_q.x  <= sat32(51'(w_q.x) + rnd_shr(prod_q, 16));
      S_I_YA: w_q.y  <= sat32(51'(w_q.y) + rnd_shr(prod_q, 16));
      S_I_FL: begin
        if (floor_hit) begin
          w_q.y <= sat32(51'(floor_q) - 51'(w_q.h));
        end
      end
      S_BNC_A: w_q.vy <= sat32(-rnd_shr(prod_q, 8));
      S_FRC_A: w_q.vx <= sat32(rnd_shr(prod_q, 16));
      S_SETTLE: begin
        if ((w_q.vy > -SETTLE_LIM) && (w_q.vy < SETTLE_LIM)) begin
          w_q.vy <= '0;
        end
      end
      S_P_RDB: a_q <= rd_rec;
      S_P_LDB: b_q <= rd_rec;
      S_P_CHK: begin
        if (a_is_dyn) begin
          w_q      <= a_q;
          s_q      <= b_q;
          w_addr_q <= i_q[IW-1:0];
        end else begin
          w_q      <= b_q;
          s_q      <= a_q;
          w_addr_q <= j_q[IW-1:0];
        end
      end
      S_P_SPAN: begin
        px_q <= span(w_q.x, w_q.w, s_q.x, s_q.w);
        py_q <= span(w_q.y, w_q.h, s_q.y, s_q.h);
      end
      S_P_RES: begin
        if (py_q <= px_q) begin
          if (w_q.y < s_q.y) begin
            w_q.y <= sat32(51'(s_q.y) - 51'(w_q.h));
          end else begin
            w_q.y <= sat32(51'(s_q.y) + 51'(s_q.h));
          end
        end else begin
          if (w_q.x < s_q.x) begin
            w_q.x <= sat32(51'(s_q.x) - 51'(w_q.w));
          end else begin
            w_q.x <= sat32(51'(s_q.x) + 51'(s_q.w));
          end
          w_q.vx <= '0;
        end
      end
      default: dv_q <= dv_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_id_o = res_id_q;
  assign out_x_o     = res_x_q;
  assign out_y_o     = res_y_q;
  assign out_w_o     = res_w_q;
  assign out_h_o     = res_h_q;
  assign status_o    = res_st_q;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for aabb_physics_step_engine_core: random and directed command
// requests, checked against a cycle-free predictor of the entity table and substep physics.
// Depends on aps_pkg and the engine RTL.
module testbench;
  import aps_pkg::*;

  localparam int          MAX_BODIES    = 64;
  localparam int          SUBSTEP_LIMIT = 8;
  localparam int          CFG_SETTLE    = 16;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          ITEM_TARGET   = 1100;
  localparam logic [3:0]  CMD_SPARE_LO  = 4'd11;
  localparam logic [3:0]  CMD_SPARE_HI  = 4'd15;

  typedef struct {
    logic [3:0]  cmd;
    logic [5:0]  id;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        dyn;
    logic        sen;
    logic [31:0] layer;
    logic [31:0] mask;
    logic [15:0] dt;
  } request_t;

  typedef struct packed {
    logic [5:0]  id;
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] w;
    logic [30:0] h;
    logic [1:0]  st;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] cmd_i = '0;
  logic [5:0] entity_id_i = '0;
  logic signed [31:0] value_x_i = '0;
  logic signed [31:0] value_y_i = '0;
  logic dynamic_flag_i = 1'b0;
  logic sensor_flag_i = 1'b0;
  logic [31:0] layer_bits_i = '0;
  logic [31:0] mask_bits_i = '0;
  logic [15:0] time_step_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [5:0] result_id_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic [30:0] out_w_o;
  logic [30:0] out_h_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  aabb_physics_step_engine_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted engine state.
  int          body_x[MAX_BODIES], body_y[MAX_BODIES];
  int          body_vx[MAX_BODIES], body_vy[MAX_BODIES];
  int          body_w[MAX_BODIES], body_h[MAX_BODIES];
  logic [2:0]  body_flags[MAX_BODIES];
  logic [31:0] body_layer[MAX_BODIES], body_mask[MAX_BODIES];
  int          body_count = 0;
  int          time_acc = 0;
  longint      gravity = 250880;
  int          floor_y = 230400;
  longint      bounce_q8 = 0;

  outcome_t pending_results[$];
  int requests_sent = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint overlap(longint p0, longint l0, longint p1, longint l1);
    longint hi, lo;
    hi = (p0 + l0 < p1 + l1) ? p0 + l0 : p1 + l1;
    lo = (p0 > p1) ? p0 : p1;
    return hi - lo;
  endfunction

  function automatic void bounce_body(int i);
    if (body_vy[i] > 0) body_vy[i] = sat(-round_shift(longint'(body_vy[i]) * bounce_q8, 8));
  endfunction

  function automatic void settle_body(int i);
    longint v;
    v = body_vy[i];
    if (v < 0) v = -v;
    if (v < longint'(SETTLE_LIM)) body_vy[i] = 0;
  endfunction

  function automatic void spawn_body(int x, int y);
    body_x[body_count] = x;
    body_y[body_count] = y;
    body_vx[body_count] = 0;
    body_vy[body_count] = 0;
    body_w[body_count] = NEW_SIZE;
    body_h[body_count] = NEW_SIZE;
    body_flags[body_count] = 3'b000;
    body_flags[body_count][F_DYN] = 1'b1;
    body_flags[body_count][F_ALIVE] = 1'b1;
    body_layer[body_count] = 32'd1;
    body_mask[body_count] = 32'hffffffff;
    body_count++;
  endfunction

  function automatic bit boxes_overlap(int a, int b);
    return body_flags[a][F_ALIVE] && body_flags[b][F_ALIVE] &&
           longint'(body_x[a]) < longint'(body_x[b]) + body_w[b] &&
           longint'(body_x[a]) + body_w[a] > longint'(body_x[b]) &&
           longint'(body_y[a]) < longint'(body_y[b]) + body_h[b] &&
           longint'(body_y[a]) + body_h[a] > longint'(body_y[b]);
  endfunction

  function automatic void run_substep();
    longint dv, px, py;
    int d, s;
    dv = (gravity * longint'(STEP_DT) + 32768) >>> 16;
    for (int i = 0; i < body_count; i++) begin
      if (!(body_flags[i][F_ALIVE] && body_flags[i][F_DYN])) continue;
      body_vy[i] = sat(longint'(body_vy[i]) + dv);
      body_x[i] = sat(longint'(body_x[i]) +
                      round_shift(longint'(body_vx[i]) * longint'(STEP_DT), 16));
      body_y[i] = sat(longint'(body_y[i]) +
                      round_shift(longint'(body_vy[i]) * longint'(STEP_DT), 16));
      if (longint'(body_y[i]) + body_h[i] > longint'(floor_y)) begin
        body_y[i] = sat(longint'(floor_y) - body_h[i]);
        bounce_body(i);
        settle_body(i);
      end
    end
    for (int i = 0; i < body_count; i++) begin
      for (int j = i + 1; j < body_count; j++) begin
        if (!boxes_overlap(i, j)) continue;
        if (body_flags[i][F_SEN] || body_flags[j][F_SEN]) continue;
        if ((body_layer[i] & body_mask[j]) == 0 && (body_layer[j] & body_mask[i]) == 0)
          continue;
        if (body_flags[i][F_DYN] == body_flags[j][F_DYN]) continue;
        d = body_flags[i][F_DYN] ? i : j;
        s = (d == i) ? j : i;
        px = overlap(body_x[d], body_w[d], body_x[s], body_w[s]);
        py = overlap(body_y[d], body_h[d], body_y[s], body_h[s]);
        if (py <= px) begin
          if (body_y[d] < body_y[s]) body_y[d] = sat(longint'(body_y[s]) - body_h[d]);
          else body_y[d] = sat(longint'(body_y[s]) + body_h[s]);
          bounce_body(d);
          body_vx[d] = sat(round_shift(longint'(body_vx[d]) * longint'(FRICTION_M), 16));
          settle_body(d);
        end else begin
          if (body_x[d] < body_x[s]) body_x[d] = sat(longint'(body_x[s]) - body_w[d]);
          else body_x[d] = sat(longint'(body_x[s]) + body_w[s]);
          body_vx[d] = 0;
        end
      end
    end
  endfunction

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t o;
    int id, dt, steps;
    id = r.id;
    o = '0;
    if (r.cmd inside {CMD_VEL, CMD_BODY, CMD_SIZE, CMD_FILTER, CMD_IMPULSE, CMD_DESTROY,
                      CMD_READ} && id >= body_count) begin
      o.st = ST_INVALID;
      return o;
    end
    case (r.cmd)
      CMD_INIT: begin
        body_count = 0;
        time_acc = 0;
        spawn_body(SPAWN_POS, SPAWN_POS);
      end
      CMD_CLEAR: begin
        body_count = 0;
        time_acc = 0;
      end
      CMD_CREATE: begin
        if (body_count >= MAX_BODIES) o.st = ST_FULL;
        else begin
          o.id = 6'(body_count);
          spawn_body(r.vx, r.vy);
        end
      end
      CMD_VEL: begin
        o.id = 6'(id);
        body_vx[id] = r.vx;
        body_vy[id] = r.vy;
      end
      CMD_BODY: begin
        o.id = 6'(id);
        body_flags[id][F_DYN] = r.dyn;
        body_flags[id][F_SEN] = r.sen;
      end
      CMD_SIZE: begin
        o.id = 6'(id);
        body_w[id] = ($signed(r.vx) < ONE_Q) ? ONE_Q : r.vx;
        body_h[id] = ($signed(r.vy) < ONE_Q) ? ONE_Q : r.vy;
      end
      CMD_FILTER: begin
        o.id = 6'(id);
        body_layer[id] = r.layer;
        body_mask[id] = r.mask;
      end
      CMD_IMPULSE: begin
        o.id = 6'(id);
        if (body_flags[id][F_DYN]) begin
          body_vx[id] = sat(longint'(body_vx[id]) + longint'($signed(r.vx)));
          body_vy[id] = sat(longint'(body_vy[id]) + longint'($signed(r.vy)));
        end else o.st = ST_INVALID;
      end
      CMD_DESTROY: begin
        o.id = 6'(id);
        body_flags[id][F_ALIVE] = 1'b0;
      end
      CMD_READ: begin
        o.id = 6'(id);
        if (body_flags[id][F_ALIVE]) begin
          o.x = body_x[id];
          o.y = body_y[id];
          o.w = body_w[id][30:0];
          o.h = body_h[id][30:0];
        end else begin
          o.x = DEAD_POS;
          o.y = DEAD_POS;
        end
      end
      CMD_STEP: begin
        dt = (r.dt > DT_CLAMP) ? DT_CLAMP : r.dt;
        time_acc += dt;
        if (time_acc > ACC_MAX) time_acc = ACC_MAX;
        steps = 0;
        while (time_acc >= STEP_DT && steps < SUBSTEP_LIMIT) begin
          run_substep();
          time_acc -= STEP_DT;
          steps++;
        end
      end
      default: o.st = ST_INVALID;
    endcase
    return o;
  endfunction

  function automatic request_t make_request(logic [3:0] cmd, int id, int vx, int vy);
    request_t r;
    r.cmd = cmd;
    r.id = 6'(id);
    r.vx = vx;
    r.vy = vy;
    r.dyn = 1'($urandom_range(1, 0));
    r.sen = ($urandom_range(3, 0) == 0);
    r.layer = $urandom;
    r.mask = $urandom;
    r.dt = 16'($urandom);
    return r;
  endfunction

  task automatic send_request(request_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= r.cmd;
    entity_id_i <= r.id;
    value_x_i <= r.vx;
    value_y_i <= r.vy;
    dynamic_flag_i <= r.dyn;
    sensor_flag_i <= r.sen;
    layer_bits_i <= r.layer;
    mask_bits_i <= r.mask;
    time_step_i <= r.dt;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.insert(pending_results.size(), predict_outcome(r));
    requests_sent++;
  endtask

  task automatic send_simple(logic [3:0] cmd, int id, int vx = 0, int vy = 0);
    send_request(make_request(cmd, id, vx, vy));
  endtask

  task automatic send_step(int dt);
    request_t r;
    r = make_request(CMD_STEP, $urandom_range(63, 0), $urandom, $urandom);
    r.dt = 16'(dt);
    send_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] index, logic [31:0] data);
    drain();
    cfg_index_i <= index;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      REG_GRAVITY: gravity = data[23:0];
      REG_FLOOR:   floor_y = data;
      REG_RESTI:   bounce_q8 = (data[8:0] > RESTI_MAX) ? RESTI_MAX : data[8:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] grav, logic [31:0] flr, logic [31:0] resti);
    write_register(REG_GRAVITY, grav);
    write_register(REG_FLOOR, flr);
    write_register(REG_RESTI, resti);
  endtask

  function automatic int random_position();
    if ($urandom_range(19, 0) == 0) return $urandom;
    return $urandom_range(240000, 0) - 10000;
  endfunction

  function automatic int random_speed();
    if ($urandom_range(19, 0) == 0) return $urandom;
    return int'($urandom_range(256000, 0)) - 128000;
  endfunction

  function automatic int pick_id();
    if (body_count == 0 || $urandom_range(9, 0) == 0) return $urandom_range(63, 0);
    return $urandom_range(body_count - 1, 0);
  endfunction

  task automatic test_directed();
    request_t r;
    send_simple(CMD_READ, 0);
    send_simple(CMD_SPARE_LO, 0);
    send_simple(CMD_SPARE_HI, 63);
    send_simple(CMD_INIT, 5);
    send_simple(CMD_READ, 0);
    send_simple(CMD_CREATE, 0, 32'sh80000000, 32'sh7fffffff);
    send_simple(CMD_CREATE, 0, 32'sh7fffffff, 32'sh80000000);
    send_simple(CMD_SIZE, 1, 0, -5);
    send_simple(CMD_SIZE, 2, 32'sh7fffffff, ONE_Q);
    send_simple(CMD_VEL, 2, 32'sh7fffffff, 32'sh80000000);
    send_simple(CMD_IMPULSE, 2, 32'sh7fffffff, 32'sh80000000);
    r = make_request(CMD_BODY, 1, 0, 0);
    r.dyn = 1'b0;
    r.sen = 1'b1;
    send_request(r);
    send_simple(CMD_IMPULSE, 1, 1000, 1000);
    r = make_request(CMD_FILTER, 0, 0, 0);
    r.layer = 32'h0;
    r.mask = 32'hffffffff;
    send_request(r);
    send_simple(CMD_DESTROY, 2);
    send_simple(CMD_READ, 2);
    send_step(0);
    send_step(16'hffff);
    send_simple(CMD_READ, 0);
    send_simple(CMD_READ, 1);
    send_simple(CMD_READ, 63);
    send_simple(CMD_CLEAR, 0);
    send_simple(CMD_READ, 0);
  endtask

  task automatic test_full_table();
    send_simple(CMD_INIT, 0);
    while (body_count < MAX_BODIES) send_simple(CMD_CREATE, 0, random_position(), 0);
    send_simple(CMD_CREATE, 0, 1, 1);
    send_simple(CMD_READ, 63);
    send_simple(CMD_CLEAR, 0);
  endtask

  task automatic test_accumulator_saturation();
    send_simple(CMD_INIT, 0);
    repeat (20) send_step(DT_CLAMP);
    send_step(16'd100);
    send_simple(CMD_READ, 0);
  endtask

  task automatic run_scene();
    request_t r;
    int n;
    if ($urandom_range(1, 0)) send_simple(CMD_INIT, 0);
    else begin
      send_simple(CMD_CLEAR, 0);
      send_simple(CMD_CREATE, 0, random_position(), random_position());
    end
    n = $urandom_range(5, 1);
    repeat (n) send_simple(CMD_CREATE, 0, random_position(), random_position());
    // A wide static platform that the falling boxes can land on.
    send_simple(CMD_CREATE, 0, $urandom_range(20000, 0), $urandom_range(220000, 120000));
    r = make_request(CMD_BODY, body_count - 1, 0, 0);
    r.dyn = 1'b0;
    r.sen = ($urandom_range(7, 0) == 0);
    send_request(r);
    send_simple(CMD_SIZE, body_count - 1, $urandom_range(200000, 20000),
                $urandom_range(20000, 0));
    repeat ($urandom_range(14, 4)) begin
      case ($urandom_range(11, 0))
        0: send_simple(CMD_VEL, pick_id(), random_speed(), random_speed());
        1: send_request(make_request(CMD_BODY, pick_id(), 0, 0));
        2: send_simple(CMD_SIZE, pick_id(), random_position() >>> 3, random_position() >>> 3);
        3: begin
          r = make_request(CMD_FILTER, pick_id(), 0, 0);
          if ($urandom_range(1, 0)) begin
            r.layer = 32'd1 << $urandom_range(2, 0);
            r.mask = 32'd1 << $urandom_range(2, 0);
          end
          send_request(r);
        end
        4: send_simple(CMD_IMPULSE, pick_id(), random_speed(), random_speed());
        5: send_simple(CMD_DESTROY, pick_id());
        6: send_request(make_request(4'($urandom), $urandom, $urandom, $urandom));
        7, 8, 9: send_step($urandom_range(9, 0) == 0 ? $urandom : $urandom_range(4000, 0));
        default: send_simple(CMD_READ, pick_id());
      endcase
    end
    for (int i = 0; i < body_count; i++) send_simple(CMD_READ, i);
  endtask

  task automatic test_random_phase(int stop_at);
    while (requests_sent < stop_at) run_scene();
  endtask

  task automatic test_stall_pressure();
    hold_left = HOLD_CYCLES;
    send_simple(CMD_INIT, 0);
    repeat (12) send_simple(CMD_CREATE, 0, random_position(), random_position());
    send_step(DT_CLAMP);
    send_simple(CMD_READ, 3);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {result_id_o, out_x_o, out_y_o, out_w_o, out_h_o, status_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: id %0d/%0d x %h/%h y %h/%h w %h/%h h %h/%h st %0d/%0d",
                     want.id, got.id, want.x, got.x, want.y, got.y, want.w, got.w,
                     want.h, got.h, want.st, got.st);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 10;
    recv_idle_pct = 57;
    test_directed();
    test_full_table();
    test_accumulator_saturation();
    configure(32'h00ffffff, 32'h7fffffff, 32'h000001ff);
    test_random_phase(ITEM_TARGET / 6);
    configure(32'h0, 32'h80000000, 32'h0);
    test_random_phase(ITEM_TARGET / 3);
    send_idle_pct = 57;
    recv_idle_pct = 10;
    configure($urandom, 32'd200000 + $urandom_range(60000, 0), $urandom);
    test_stall_pressure();
    test_random_phase(ITEM_TARGET / 2);
    configure($urandom, $urandom, 32'd256);
    test_random_phase(ITEM_TARGET * 2 / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(32'd250880, 32'd230400, 32'd128);
    test_random_phase(ITEM_TARGET);
    drain();
    if (mismatches == 0) begin
      $display("aabb_physics_step_engine_core verification clean");
    end else begin
      $display("aabb_physics_step_engine_core verification failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("aabb_physics_step_engine_core verification failed");
    $finish;
  end

endmodule
